@@ hw/rtl/tsre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_pkg: shared types and constants for the transparent-run sprite encoder
// Token codes, register indexes and the token bundle passed from the front
// end to the back end through the bundle queue.
// ----------------------------------------------------------------------------
package tsre_pkg;

   // field widths
   localparam int PIXEL_W  = 8;
   localparam int HEIGHT_W = 8;
   localparam int RUN_W    = 8;
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 17;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // token kinds
   localparam logic [KIND_W-1:0] KIND_JUMP  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPARENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT      = 2'd1;

   // tokens per input word and bundle queue size
   localparam int MAX_TOKENS  = 3;
   localparam int TOK_CNT_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } token_type;

   // all tokens caused by one input word
   typedef struct packed {
      logic [TOK_CNT_W-1:0] count;
      token_type [MAX_TOKENS-1:0] tok;
      logic                 stream_end;
   } bundle_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hw/rtl/tsre_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_front: pixel classifier and encoder state
// Accepts one pixel word a cycle unless the queue is full, tracks column
// position, pending jump and open run, and pushes a pixel's tokens as a bundle.
// ----------------------------------------------------------------------------
module tsre_front
   import tsre_pkg::*;
#(
   parameter int SCREEN_STRIDE = 240
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic                  req_sprite_end,
   input  logic [PIXEL_W-1:0]    transparent_color,
   input  logic [HEIGHT_W-1:0]   sprite_height,
   input  queue_status_type      q_status,
   output logic                  push,
   output bundle_type            push_bundle
);

   localparam int STRIDE_W = $clog2(SCREEN_STRIDE + 1);
   localparam int GAP_W    = (STRIDE_W > HEIGHT_W) ? STRIDE_W : HEIGHT_W;
   localparam int SUM_W    = VALUE_W + 2;
   localparam logic [GAP_W-1:0] STRIDE_C = GAP_W'(SCREEN_STRIDE);

   logic [HEIGHT_W-1:0] row_ff,      row_in;
   logic [VALUE_W-1:0]  pend_ff,     pend_in;
   logic                run_open_ff, run_open_in;
   logic [RUN_W-1:0]    run_len_ff,  run_len_in;
   logic                first_ff,    first_in;

   logic                accept;
   logic [GAP_W-1:0]    gap;
   logic                col_end;
   logic                trans;
   logic [SUM_W-1:0]    lead_sum;
   logic [SUM_W-1:0]    total_sum;
   logic [VALUE_W-1:0]  lead_jump;
   logic [VALUE_W-1:0]  total_jump;
   logic [RUN_W-1:0]    run_len_next;
   token_type           tok_size_old, tok_lead, tok_pixel, tok_size_new, tok_tail;

   function automatic logic [VALUE_W-1:0] sat(input logic [SUM_W-1:0] x);
      sat = (x > SUM_W'(VALUE_MAX)) ? VALUE_MAX : x[VALUE_W-1:0];
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // classify the pixel and work out column end and screen gap
   always_comb begin
      gap     = (STRIDE_C > GAP_W'(sprite_height)) ? (STRIDE_C - GAP_W'(sprite_height))
                                                   : '0;
      col_end = req_sprite_end ||
                ({1'b0, row_ff} + 9'd1 >= {1'b0, sprite_height});
      trans   = (req_pixel == transparent_color);
   end

   // jump sums: all added terms are non-negative, so one saturation suffices
   always_comb begin
      lead_sum  = SUM_W'(pend_ff) + (first_ff ? SUM_W'(gap) : '0);
      total_sum = lead_sum + (col_end ? SUM_W'(gap) : '0) + SUM_W'(trans);
      lead_jump  = sat(lead_sum);
      total_jump = sat(total_sum);
      run_len_next = run_open_ff ? (run_len_ff + 1'b1) : RUN_W'(1);
   end

   // candidate tokens
   always_comb begin
      tok_size_old = '{kind: KIND_SIZE,  value: VALUE_W'(run_len_ff)};
      tok_lead     = '{kind: KIND_JUMP,  value: lead_jump};
      tok_pixel    = '{kind: KIND_PIXEL, value: VALUE_W'(req_pixel)};
      tok_size_new = '{kind: KIND_SIZE,  value: VALUE_W'(run_len_next)};
      tok_tail     = '{kind: KIND_JUMP,  value: total_jump};
   end

   // pack tokens in output order
   always_comb begin
      push_bundle            = '0;
      push_bundle.stream_end = req_sprite_end;
      if (trans) begin
         if (run_open_ff) begin
            push_bundle.tok[0] = tok_size_old;
            push_bundle.tok[1] = tok_tail;
            push_bundle.count  = req_sprite_end ? 2'd2 : 2'd1;
         end else begin
            push_bundle.tok[0] = tok_tail;
            push_bundle.count  = req_sprite_end ? 2'd1 : 2'd0;
         end
      end else begin
         if (!run_open_ff) begin
            push_bundle.tok[0] = tok_lead;
            push_bundle.tok[1] = tok_pixel;
            push_bundle.tok[2] = tok_size_new;
            push_bundle.count  = col_end ? 2'd3 : 2'd2;
         end else begin
            push_bundle.tok[0] = tok_pixel;
            push_bundle.tok[1] = tok_size_new;
            push_bundle.count  = col_end ? 2'd2 : 2'd1;
         end
      end
      push = accept && (push_bundle.count != '0);
   end

   // next encoder state; sprite end returns everything to the reset values
   always_comb begin
      run_open_in = !trans && !col_end;
      run_len_in  = run_open_in ? run_len_next : '0;
      row_in      = col_end ? '0 : (row_ff + 1'b1);
      first_in    = 1'b0;
      if (!trans && !run_open_ff)
         pend_in = col_end ? VALUE_W'(gap) : '0;
      else
         pend_in = total_jump;
      if (req_sprite_end) begin
         run_open_in = 1'b0;
         run_len_in  = '0;
         row_in      = '0;
         pend_in     = '0;
         first_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         pend_ff     <= '0;
         run_open_ff <= 1'b0;
         run_len_ff  <= '0;
         first_ff    <= 1'b1;
      end else if (accept) begin
         row_ff      <= row_in;
         pend_ff     <= pend_in;
         run_open_ff <= run_open_in;
         run_len_ff  <= run_len_in;
         first_ff    <= first_in;
      end
   end

endmodule

@@ hw/rtl/tsre_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_queue: bundle queue between front and back end
// Small register FIFO of token bundles; the head is visible without a pop.
// ----------------------------------------------------------------------------
module tsre_queue
   import tsre_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bundle_type        push_bundle,
   input  logic              pop,
   output bundle_type        head,
   output queue_status_type  q_status
);

   bundle_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff,  count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      q_status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_bundle;
   end

endmodule

@@ hw/rtl/tsre_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_back: token serializer and output register
// Walks the head bundle into the result register one token a cycle unless
// stalled, pops the bundle after its last token, marks item and stream ends.
// ----------------------------------------------------------------------------
module tsre_back
   import tsre_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  queue_status_type   q_status,
   input  bundle_type         head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_item_done,
   output logic               rsp_stream_done
);

   logic                  valid_ff, valid_in;
   logic [TOK_CNT_W-1:0]  idx_ff,   idx_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic                  item_done_ff;
   logic                  stream_done_ff;

   logic                  load;
   logic                  take;
   logic                  last_tok;
   token_type             cur_tok;

   // pick the next token when the output register frees up
   always_comb begin
      load     = !valid_ff || !rsp_stall;
      take     = load && !q_status.empty;
      last_tok = (idx_ff == (head.count - 1'b1));
      cur_tok  = head.tok[idx_ff];
      pop      = take && last_tok;
      valid_in = load ? !q_status.empty : valid_ff;
      idx_in   = take ? (last_tok ? '0 : (idx_ff + 1'b1)) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff        <= cur_tok.kind;
         value_ff       <= cur_tok.value;
         item_done_ff   <= last_tok;
         stream_done_ff <= last_tok && head.stream_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_value       = value_ff;
   assign rsp_item_done   = item_done_ff;
   assign rsp_stream_done = stream_done_ff;

endmodule

@@ hw/rtl/transparent_run_sprite_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transparent_run_sprite_encoder: column-major sprite to jump/pixel/size tokens
// Path: front end, bundle queue, then the output register of the back end.
// Throughput: one pixel word per cycle while each causes at most one token
//   and the output is not stalled; the back end emits one token a cycle.
// Reset: synchronous; clears encoder state, the queue and the output register,
//   and sets transparent color 0 and sprite height 32.
// ----------------------------------------------------------------------------
module transparent_run_sprite_encoder
   import tsre_pkg::*;
#(
   parameter int SCREEN_STRIDE = 240
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic                  req_sprite_end,
   // tokens
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [VALUE_W-1:0]    rsp_value,
   output logic                  rsp_item_done,
   output logic                  rsp_stream_done,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PIXEL_W-1:0]    csr_data
);

   logic [PIXEL_W-1:0]  transparent_ff;
   logic [HEIGHT_W-1:0] height_ff;

   queue_status_type    q_status;
   logic                push;
   logic                pop;
   bundle_type          push_bundle;
   bundle_type          head;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_ff <= '0;
         height_ff      <= HEIGHT_W'(32);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRANSPARENT: transparent_ff <= csr_data;
            CSR_HEIGHT:      height_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   tsre_front #(
      .SCREEN_STRIDE (SCREEN_STRIDE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_sprite_end    (req_sprite_end),
      .transparent_color (transparent_ff),
      .sprite_height     (height_ff),
      .q_status          (q_status),
      .push              (push),
      .push_bundle       (push_bundle)
   );

   tsre_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .q_status    (q_status)
   );

   tsre_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_item_done   (rsp_item_done),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule
